FILE: rtl/core/bcu_pkg.sv
// Shared constants and control types for the binomial coefficient unit.
// No dependencies; imported by the controller, the datapath and the top level.
package bcu_pkg;

    localparam int FIELD_W = 6;                 // row / position width
    localparam int COEF_W  = 32;                // result width
    localparam int FACT_W  = 6;                 // multiplier factor n - i
    localparam int PROD_W  = COEF_W + FACT_W;   // wide intermediate product
    localparam int STEP_W  = 5;                 // step index, up to 17
    localparam int DIVS_W  = 5;                 // divisor i + 1, up to 17
    localparam int BIT_W   = 6;                 // divider bit counter
    localparam int MAX_ROW = 34;

    localparam logic [BIT_W-1:0] LAST_BIT = BIT_W'(PROD_W - 1);

    typedef struct packed {
        logic              load;      // take a new word, set acc to one
        logic              mul;       // form acc * (n - index), clear remainder
        logic              div_step;  // one restoring division bit
        logic              div_last;  // final division bit: write quotient to acc
        logic              publish;   // copy result into output register
        logic [STEP_W-1:0] index;     // current step i
    } bcu_cmd_t;

    typedef struct packed {
        logic [STEP_W-1:0] steps;     // min(k, n - k), zero when out of range
    } bcu_sts_t;

endpackage

FILE: rtl/core/binomial_coefficient_unit.sv
// Binomial coefficient unit: C(n,k) by s = min(k, n-k) multiply/exact-divide steps.
// Once all steps are done, the result is published when the output register is free; the
// next word is then taken, so a new word is not taken while one is being computed.
// Each step is a multiply followed by a bit-serial restoring divider.
// A finished word waits in the output register while the next word is taken.
// aresetn (synchronous, active low) clears the controller and output valid.
// Depends on bcu_pkg, bcu_ctrl, bcu_datapath.
module binomial_coefficient_unit
    import bcu_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [FIELD_W-1:0]  s_row,
    input  logic [FIELD_W-1:0]  s_position,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [COEF_W-1:0]   m_coefficient,
    output logic                m_out_of_range
);

    bcu_cmd_t cmd;
    bcu_sts_t sts;

    bcu_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    bcu_datapath u_datapath (
        .aclk         (aclk),
        .row          (s_row),
        .position     (s_position),
        .cmd          (cmd),
        .sts          (sts),
        .coefficient  (m_coefficient),
        .out_of_range (m_out_of_range)
    );

endmodule

FILE: rtl/core/bcu_datapath.sv
// Datapath: operand registers, 32x6 multiplier and bit-serial exact divider.
// Depends on bcu_pkg; driven by bcu_ctrl commands.
module bcu_datapath
    import bcu_pkg::*;
(
    input  logic                aclk,
    input  logic [FIELD_W-1:0]  row,
    input  logic [FIELD_W-1:0]  position,
    input  bcu_cmd_t            cmd,
    output bcu_sts_t            sts,
    output logic [COEF_W-1:0]   coefficient,
    output logic                out_of_range
);

    logic [FIELD_W-1:0] n_reg,    n_next;
    logic [STEP_W-1:0]  steps_reg, steps_next;
    logic               oor_reg,  oor_next;
    logic [COEF_W-1:0]  acc_reg,  acc_next;
    logic [PROD_W-1:0]  dvd_reg,  dvd_next;
    logic [DIVS_W-1:0]  rem_reg,  rem_next;
    logic [DIVS_W-1:0]  divs_reg, divs_next;
    logic [COEF_W-1:0]  coef_reg, coef_next;
    logic               oor_out_reg, oor_out_next;

    logic               in_oor;
    logic [FIELD_W-1:0] diff;
    logic [FIELD_W-1:0] min_k;
    logic [FACT_W-1:0]  factor;
    logic [DIVS_W:0]    trial;
    logic               ge;
    logic [DIVS_W:0]    trial_sub;
    logic [PROD_W-1:0]  shifted;

    always_comb begin
        in_oor    = (position > row) || (row > FIELD_W'(MAX_ROW));
        diff      = row - position;
        min_k     = (position > diff) ? diff : position;

        factor    = n_reg - FACT_W'(cmd.index);
        trial     = {rem_reg, dvd_reg[PROD_W-1]};
        ge        = trial >= {1'b0, divs_reg};
        trial_sub = trial - {1'b0, divs_reg};
        shifted   = {dvd_reg[PROD_W-2:0], ge};

        n_next       = n_reg;
        steps_next   = steps_reg;
        oor_next     = oor_reg;
        acc_next     = acc_reg;
        dvd_next     = dvd_reg;
        rem_next     = rem_reg;
        divs_next    = divs_reg;
        coef_next    = coef_reg;
        oor_out_next = oor_out_reg;

        if (cmd.load) begin
            n_next     = row;
            oor_next   = in_oor;
            steps_next = in_oor ? '0 : min_k[STEP_W-1:0];
            acc_next   = COEF_W'(1);
        end
        if (cmd.mul) begin
            dvd_next  = PROD_W'(acc_reg) * PROD_W'(factor);
            rem_next  = '0;
            divs_next = DIVS_W'(cmd.index) + DIVS_W'(1);
        end
        if (cmd.div_step) begin
            rem_next = ge ? trial_sub[DIVS_W-1:0] : trial[DIVS_W-1:0];
            dvd_next = shifted;
            // exact quotient is an intermediate coefficient, fits 32 bits
            if (cmd.div_last) begin
                acc_next = shifted[COEF_W-1:0];
            end
        end
        if (cmd.publish) begin
            coef_next    = oor_reg ? '0 : acc_reg;
            oor_out_next = oor_reg;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg       <= n_next;
        steps_reg   <= steps_next;
        oor_reg     <= oor_next;
        acc_reg     <= acc_next;
        dvd_reg     <= dvd_next;
        rem_reg     <= rem_next;
        divs_reg    <= divs_next;
        coef_reg    <= coef_next;
        oor_out_reg <= oor_out_next;
    end

    assign sts.steps    = steps_reg;
    assign coefficient  = coef_reg;
    assign out_of_range = oor_out_reg;

endmodule

FILE: rtl/core/bcu_ctrl.sv
// Controller: sequences load, multiply and division steps, owns both handshakes.
// Depends on bcu_pkg; commands bcu_datapath.
module bcu_ctrl
    import bcu_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    input  bcu_sts_t sts,
    output bcu_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_STEP,
        ST_DIV,
        ST_FIN
    } state_t;

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] idx_reg,   idx_next;
    logic [BIT_W-1:0]  bit_reg,   bit_next;
    logic              m_valid_reg, m_valid_next;
    logic              out_free;

    always_comb begin
        out_free     = !m_valid_reg || m_ready;
        state_next   = state_reg;
        idx_next     = idx_reg;
        bit_next     = bit_reg;
        cmd          = '0;
        cmd.index    = idx_reg;
        s_ready      = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    idx_next   = '0;
                    state_next = ST_STEP;
                end
            end
            ST_STEP: begin
                if (idx_reg == sts.steps) begin
                    state_next = ST_FIN;
                end else begin
                    cmd.mul    = 1'b1;
                    bit_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                bit_next     = bit_reg + BIT_W'(1);
                if (bit_reg == LAST_BIT) begin
                    cmd.div_last = 1'b1;
                    idx_next     = idx_reg + STEP_W'(1);
                    state_next   = ST_STEP;
                end
            end
            ST_FIN: begin
                // hold until the output register can take the word
                if (out_free) begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (cmd.publish) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            bit_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            bit_reg     <= bit_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule
